// ===== hw/rtl/dtq_pkg.sv =====
`default_nettype none
package dtq_pkg;

   localparam int DEF_CAPACITY  = 16;
   localparam int DEF_TAG_BITS  = 16;
   localparam int DEF_TIME_BITS = 32;
   localparam int OP_BITS       = 3;
   localparam int LIMIT_BITS    = 5;
   localparam int DROP_BITS     = 32;

   typedef enum logic [OP_BITS-1:0] {
      OP_POST       = 3'd0,
      OP_POST_AT    = 3'd1,
      OP_POST_AFTER = 3'd2,
      OP_POLL       = 3'd3,
      OP_STOP       = 3'd4,
      OP_RESTART    = 3'd5
   } op_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_EXEC,
      S_SCAN,
      S_DECIDE,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_POP,
      S_POP_DATA,
      S_DONE
   } state_type;

endpackage
`default_nettype wire

// ===== hw/rtl/dtq_ram.sv =====
`default_nettype none
module dtq_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

// ===== hw/rtl/delayed_task_queue.sv =====
`default_nettype none
// delayed task queue: ready fifo plus deadline store of task tags
// req channel carries one operation (post, post at, post after delay, poll,
// stop, restart) with tag, time value and current time; rsp returns one
// result per request: accepted, task_valid, out_tag, pending count, drop
// total and stop flag
// csr_wr_en writes the pending limit (max_entries); the user writes it only while
// the block is idle, which the block itself does not enforce
// a post, stop or restart passes through S_EXEC and then S_DONE; a poll that is
// not stopped scans the deadline store through its single read port, one entry
// a cycle, then, when a due entry moves to the fifo, shifts later entries down,
// each through S_SHIFT_RD and S_SHIFT_WR, then reads the fifo head in S_POP and
// S_POP_DATA; S_DONE waits for a free output register, loads it, raises rsp_valid
// the next request can transfer in the same cycle that rsp_valid rises
// one request is in flight at a time; req_stall is high until its result
// has been loaded into the output register
// reset clears counts, flags, drop count and limit; memories need no clear
// when rsp_stall is high the result holds and the next result waits
module delayed_task_queue
   import dtq_pkg::*;
#(
   parameter int CAPACITY  = DEF_CAPACITY,
   parameter int TAG_BITS  = DEF_TAG_BITS,
   parameter int TIME_BITS = DEF_TIME_BITS
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_wr_en,
   input  wire logic [dtq_pkg::LIMIT_BITS-1:0] csr_wr_data,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [dtq_pkg::OP_BITS-1:0]    req_operation,
   input  wire logic [TAG_BITS-1:0]            req_task_tag,
   input  wire logic [TIME_BITS-1:0]           req_time_value,
   input  wire logic [TIME_BITS-1:0]           req_now,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic                                rsp_accepted,
   output logic                                rsp_task_valid,
   output logic [TAG_BITS-1:0]                 rsp_out_tag,
   output logic [dtq_pkg::LIMIT_BITS-1:0]      rsp_pending_count,
   output logic [dtq_pkg::DROP_BITS-1:0]       rsp_dropped_total,
   output logic                                rsp_stopped
);

   localparam int IW  = $clog2(CAPACITY);
   localparam int CW  = $clog2(CAPACITY + 1);
   localparam int SW  = CW + 1;
   localparam int PW  = $clog2(2 * CAPACITY + 1);
   localparam int LW  = (PW > LIMIT_BITS) ? PW : LIMIT_BITS;
   localparam int EW  = TIME_BITS + TAG_BITS;

   state_type state_ff, state_in;

   logic [LIMIT_BITS-1:0] max_ff;
   logic [OP_BITS-1:0]    op_ff;
   logic [TAG_BITS-1:0]   tag_ff;
   logic [TIME_BITS-1:0]  tval_ff, now_ff;

   logic [IW-1:0] head_ff, head_in;
   logic [CW-1:0] rcnt_ff, rcnt_in;
   logic [CW-1:0] tcnt_ff, tcnt_in;
   logic [DROP_BITS-1:0] drop_ff, drop_in;
   logic stop_ff, stop_in;

   logic [IW-1:0] scan_ff, scan_in;
   logic [IW-1:0] cmp_ff, cmp_in;
   logic [IW-1:0] best_ff, best_in;
   logic [TIME_BITS-1:0] btime_ff, btime_in;
   logic [TAG_BITS-1:0]  btag_ff, btag_in;
   logic [IW-1:0] sh_ff, sh_in;

   logic acc_ff, acc_in;
   logic tv_ff, tv_in;
   logic [TAG_BITS-1:0] otag_ff, otag_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_acc_ff, rsp_tv_ff, rsp_stop_ff;
   logic [TAG_BITS-1:0] rsp_tag_ff;
   logic [LIMIT_BITS-1:0] rsp_pend_ff;
   logic [DROP_BITS-1:0] rsp_drop_ff;

   logic          r_we;
   logic [IW-1:0] r_waddr, r_raddr;
   logic [TAG_BITS-1:0] r_wdata, r_rdata;
   logic          t_we;
   logic [IW-1:0] t_waddr, t_raddr;
   logic [EW-1:0] t_wdata, t_rdata;

   logic [LW-1:0] pend, limit;
   logic          admit;
   logic [SW-1:0] tail_sum;
   logic [IW-1:0] tail;
   logic [TIME_BITS:0] when_sum;
   logic [TIME_BITS-1:0] when_sat;
   logic [TIME_BITS-1:0] rd_time;
   logic [TAG_BITS-1:0]  rd_tag;
   logic out_free, req_xfer;

   dtq_ram #(.DEPTH(CAPACITY), .WIDTH(TAG_BITS)) u_ready_ram (
      .clock   (clock),
      .wr_en   (r_we),
      .wr_addr (r_waddr),
      .wr_data (r_wdata),
      .rd_addr (r_raddr),
      .rd_data (r_rdata)
   );

   dtq_ram #(.DEPTH(CAPACITY), .WIDTH(EW)) u_timed_ram (
      .clock   (clock),
      .wr_en   (t_we),
      .wr_addr (t_waddr),
      .wr_data (t_wdata),
      .rd_addr (t_raddr),
      .rd_data (t_rdata)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign pend = LW'(rcnt_ff) + LW'(tcnt_ff);
   assign limit = (max_ff == '0 || LW'(max_ff) > LW'(CAPACITY)) ? LW'(CAPACITY)
                                                                 : LW'(max_ff);
   assign admit = (pend < limit);
   assign tail_sum = SW'(head_ff) + SW'(rcnt_ff);
   assign tail = (tail_sum >= SW'(CAPACITY)) ? IW'(tail_sum - SW'(CAPACITY))
                                             : tail_sum[IW-1:0];
   assign when_sum = {1'b0, now_ff} + {1'b0, tval_ff};
   assign when_sat = when_sum[TIME_BITS] ? '1 : when_sum[TIME_BITS-1:0];
   assign rd_time = t_rdata[EW-1:TAG_BITS];
   assign rd_tag  = t_rdata[TAG_BITS-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) state_in = S_EXEC;
         end
         S_EXEC: begin
            if (op_ff == OP_POLL && !stop_ff) begin
               state_in = (tcnt_ff != '0) ? S_SCAN : S_POP;
            end else begin
               state_in = S_DONE;
            end
         end
         S_SCAN: begin
            if (CW'(cmp_ff) == tcnt_ff - CW'(1)) state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (btime_ff <= now_ff && rcnt_ff < CW'(CAPACITY)) state_in = S_SHIFT_RD;
            else state_in = S_POP;
         end
         S_SHIFT_RD: begin
            state_in = (CW'(sh_ff) < tcnt_ff) ? S_SHIFT_WR : S_POP;
         end
         S_SHIFT_WR: state_in = S_SHIFT_RD;
         S_POP: begin
            state_in = (rcnt_ff != '0) ? S_POP_DATA : S_DONE;
         end
         S_POP_DATA: state_in = S_DONE;
         S_DONE: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      head_in = head_ff;
      rcnt_in = rcnt_ff;
      tcnt_in = tcnt_ff;
      drop_in = drop_ff;
      stop_in = stop_ff;
      scan_in = scan_ff;
      cmp_in = cmp_ff;
      best_in = best_ff;
      btime_in = btime_ff;
      btag_in = btag_ff;
      sh_in = sh_ff;
      acc_in = acc_ff;
      tv_in = tv_ff;
      otag_in = otag_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      r_we = 1'b0;
      r_waddr = tail;
      r_wdata = tag_ff;
      r_raddr = head_ff;
      t_we = 1'b0;
      t_waddr = tcnt_ff[IW-1:0];
      t_wdata = {tval_ff, tag_ff};
      t_raddr = scan_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               acc_in = 1'b0;
               tv_in = 1'b0;
               otag_in = '0;
            end
         end
         S_EXEC: begin
            unique case (op_ff)
               OP_POST, OP_POST_AT, OP_POST_AFTER: begin
                  if (admit) begin
                     acc_in = 1'b1;
                     if (op_ff == OP_POST
                         || (op_ff == OP_POST_AFTER && tval_ff == '0)) begin
                        r_we = 1'b1;
                        rcnt_in = rcnt_ff + CW'(1);
                     end else begin
                        t_we = 1'b1;
                        if (op_ff == OP_POST_AFTER) t_wdata = {when_sat, tag_ff};
                        tcnt_in = tcnt_ff + CW'(1);
                     end
                  end else if (drop_ff != '1) begin
                     drop_in = drop_ff + DROP_BITS'(1);
                  end
               end
               OP_POLL: begin
                  t_raddr = '0;
                  scan_in = IW'(1);
                  cmp_in = '0;
               end
               OP_STOP: begin
                  if (!stop_ff) begin
                     drop_in = '0;
                     stop_in = 1'b1;
                     head_in = '0;
                     rcnt_in = '0;
                     tcnt_in = '0;
                  end
               end
               OP_RESTART: begin
                  drop_in = '0;
                  stop_in = 1'b0;
               end
               default: ;
            endcase
         end
         S_SCAN: begin
            t_raddr = scan_ff;
            scan_in = scan_ff + IW'(1);
            cmp_in = cmp_ff + IW'(1);
            if (cmp_ff == '0 || rd_time < btime_ff) begin
               best_in = cmp_ff;
               btime_in = rd_time;
               btag_in = rd_tag;
            end
         end
         S_DECIDE: begin
            if (btime_ff <= now_ff && rcnt_ff < CW'(CAPACITY)) begin
               r_we = 1'b1;
               r_wdata = btag_ff;
               rcnt_in = rcnt_ff + CW'(1);
               tcnt_in = tcnt_ff - CW'(1);
               sh_in = best_ff;
            end
         end
         S_SHIFT_RD: begin
            t_raddr = sh_ff + IW'(1);
         end
         S_SHIFT_WR: begin
            t_we = 1'b1;
            t_waddr = sh_ff;
            t_wdata = t_rdata;
            sh_in = sh_ff + IW'(1);
         end
         S_POP: begin
            r_raddr = head_ff;
         end
         S_POP_DATA: begin
            tv_in = 1'b1;
            otag_in = r_rdata;
            head_in = (head_ff == IW'(CAPACITY - 1)) ? '0 : head_ff + IW'(1);
            rcnt_in = rcnt_ff - CW'(1);
         end
         S_DONE: begin
            if (out_free) rsp_valid_in = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         max_ff <= '0;
         head_ff <= '0;
         rcnt_ff <= '0;
         tcnt_ff <= '0;
         drop_ff <= '0;
         stop_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) max_ff <= csr_wr_data;
         head_ff <= head_in;
         rcnt_ff <= rcnt_in;
         tcnt_ff <= tcnt_in;
         drop_ff <= drop_in;
         stop_ff <= stop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         op_ff <= req_operation;
         tag_ff <= req_task_tag;
         tval_ff <= req_time_value;
         now_ff <= req_now;
      end
      scan_ff <= scan_in;
      cmp_ff <= cmp_in;
      best_ff <= best_in;
      btime_ff <= btime_in;
      btag_ff <= btag_in;
      sh_ff <= sh_in;
      acc_ff <= acc_in;
      tv_ff <= tv_in;
      otag_ff <= otag_in;
      if (state_ff == S_DONE && out_free) begin
         rsp_acc_ff <= acc_ff;
         rsp_tv_ff <= tv_ff;
         rsp_tag_ff <= otag_ff;
         rsp_pend_ff <= pend[LIMIT_BITS-1:0];
         rsp_drop_ff <= drop_ff;
         rsp_stop_ff <= stop_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_accepted      = rsp_acc_ff;
   assign rsp_task_valid    = rsp_tv_ff;
   assign rsp_out_tag       = rsp_tag_ff;
   assign rsp_pending_count = rsp_pend_ff;
   assign rsp_dropped_total = rsp_drop_ff;
   assign rsp_stopped       = rsp_stop_ff;

   a_pend_cap: assert property (@(posedge clock) disable iff (reset)
      pend <= LW'(CAPACITY))
      else $error("pending count above capacity");

   a_stop_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC && op_ff == OP_STOP && !stop_ff)
      |=> (rcnt_ff == '0 && tcnt_ff == '0 && drop_ff == '0 && stop_ff))
      else $error("stop did not clear the stores");

   a_poll_stopped: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC && op_ff == OP_POLL && stop_ff) |=> state_ff == S_DONE)
      else $error("poll ran while stopped");

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
module tb;
   import dtq_pkg::*;

   localparam int CAP        = DEF_CAPACITY;
   localparam int DRAIN_WAIT = 80;
   localparam int CYCLE_CAP  = 1000000;

   typedef struct packed {
      logic        accepted;
      logic        task_valid;
      logic [15:0] out_tag;
      logic [4:0]  pending;
      logic [31:0] dropped;
      logic        stopped;
   } outcome_type;

   typedef struct packed {
      logic [31:0] deadline;
      logic [15:0] tag;
   } timed_type;

   class task_queue_scoreboard;
      logic [15:0] ready_q[$];
      timed_type   timed_q[$];
      logic [31:0] drops;
      logic        halted;
      logic [4:0]  limit_reg;
      outcome_type outcome_q[$];
      int          errors;
      int          items;
      int          handed_out;
      int          refused;

      function void clear_all();
         ready_q.delete();
         timed_q.delete();
         outcome_q.delete();
         drops = 0;
         halted = 0;
         limit_reg = 0;
         errors = 0;
         items = 0;
         handed_out = 0;
         refused = 0;
      endfunction

      function bit room();
         int lim;
         lim = limit_reg;
         if (lim == 0 || lim > CAP) lim = CAP;
         if (ready_q.size() + timed_q.size() < lim) return 1;
         if (drops != 32'hffff_ffff) drops++;
         refused++;
         return 0;
      endfunction

      function void note(op_type op, logic [15:0] tag, logic [31:0] tval, logic [31:0] now);
         outcome_type o;
         logic [32:0] sum;
         timed_type e;
         int best;
         o = '0;
         items++;
         case (op)
            OP_POST: if (room()) begin
               ready_q.push_back(tag);
               o.accepted = 1;
            end
            OP_POST_AT: if (room()) begin
               e.deadline = tval;
               e.tag = tag;
               timed_q.push_back(e);
               o.accepted = 1;
            end
            OP_POST_AFTER: if (room()) begin
               if (tval == 0) begin
                  ready_q.push_back(tag);
               end else begin
                  sum = {1'b0, now} + {1'b0, tval};
                  e.deadline = sum[32] ? 32'hffff_ffff : sum[31:0];
                  e.tag = tag;
                  timed_q.push_back(e);
               end
               o.accepted = 1;
            end
            OP_POLL: if (!halted) begin
               if (timed_q.size() > 0) begin
                  best = 0;
                  for (int i = 1; i < timed_q.size(); i++)
                     if (timed_q[i].deadline < timed_q[best].deadline) best = i;
                  if (timed_q[best].deadline <= now && ready_q.size() < CAP) begin
                     ready_q.push_back(timed_q[best].tag);
                     timed_q.delete(best);
                  end
               end
               if (ready_q.size() > 0) begin
                  o.out_tag = ready_q.pop_front();
                  o.task_valid = 1;
                  handed_out++;
               end
            end
            OP_STOP: if (!halted) begin
               drops = 0;
               halted = 1;
               ready_q.delete();
               timed_q.delete();
            end
            OP_RESTART: begin
               drops = 0;
               halted = 0;
            end
            default: ;
         endcase
         o.pending = 5'(ready_q.size() + timed_q.size());
         o.dropped = drops;
         o.stopped = halted;
         outcome_q.push_back(o);
      endfunction

      function void check(outcome_type got);
         outcome_type want;
         if (outcome_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result %p", got);
            return;
         end
         want = outcome_q.pop_front();
         if (got !== want) begin
            errors++;
            if (errors <= 10) $display("result mismatch: expected %p actual %p", want, got);
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_wr_en = 0;
   logic [4:0]  csr_wr_data = 0;
   logic        req_valid = 0;
   logic        req_stall;
   logic [2:0]  req_operation = 0;
   logic [15:0] req_task_tag = 0;
   logic [31:0] req_time_value = 0;
   logic [31:0] req_now = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic        rsp_accepted;
   logic        rsp_task_valid;
   logic [15:0] rsp_out_tag;
   logic [4:0]  rsp_pending_count;
   logic [31:0] rsp_dropped_total;
   logic        rsp_stopped;

   task_queue_scoreboard sb;
   bit          idle_on = 1;
   bit          long_hold_go = 0;
   int          cycles = 0;
   logic [31:0] now_t = 0;

   delayed_task_queue u_dut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_operation(req_operation), .req_task_tag(req_task_tag),
      .req_time_value(req_time_value), .req_now(req_now),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_accepted(rsp_accepted), .rsp_task_valid(rsp_task_valid),
      .rsp_out_tag(rsp_out_tag), .rsp_pending_count(rsp_pending_count),
      .rsp_dropped_total(rsp_dropped_total), .rsp_stopped(rsp_stopped)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_CAP) begin
            $display("delayed_task_queue: mismatch");
            $finish;
         end
      end
   end

   // result side: checks each transfer and picks the next stall value
   initial begin
      int hold_left;
      int burst_left;
      hold_left = 0;
      burst_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            sb.check({rsp_accepted, rsp_task_valid, rsp_out_tag, rsp_pending_count,
                      rsp_dropped_total, rsp_stopped});
         if (long_hold_go) begin
            hold_left = 300;
            long_hold_go = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1;
         end else if (burst_left > 0) begin
            burst_left--;
            rsp_stall <= 1;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            burst_left = $urandom_range(0, 2);
            rsp_stall <= 1;
         end else begin
            rsp_stall <= 0;
         end
      end
   end

   task automatic send(op_type op, logic [15:0] tag, logic [31:0] tval, logic [31:0] now);
      req_valid <= 1;
      req_operation <= op;
      req_task_tag <= tag;
      req_time_value <= tval;
      req_now <= now;
      do @(posedge clock); while (req_stall);
      sb.note(op, tag, tval, now);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.outcome_q.size() > 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_limit(logic [4:0] v);
      drain();
      csr_wr_en <= 1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 0;
      sb.limit_reg = v;
   endtask

   task automatic random_item();
      int pick;
      logic [15:0] tag;
      logic [31:0] tval;
      pick = $urandom_range(0, 99);
      tag = 16'($urandom);
      case ($urandom_range(0, 19))
         0: now_t = $urandom;
         1: now_t = now_t + $urandom_range(100, 5000);
         default: now_t = now_t + $urandom_range(0, 12);
      endcase
      if (pick < 20) begin
         send(OP_POST, tag, $urandom, now_t);
      end else if (pick < 42) begin
         tval = ($urandom_range(0, 7) == 0) ? $urandom : now_t + $urandom_range(0, 80);
         send(OP_POST_AT, tag, tval, now_t);
      end else if (pick < 62) begin
         case ($urandom_range(0, 7))
            0: tval = 0;
            1: tval = $urandom;
            default: tval = $urandom_range(1, 60);
         endcase
         send(OP_POST_AFTER, tag, tval, now_t);
      end else if (pick < 93) begin
         send(OP_POLL, tag, $urandom, now_t);
      end else if (pick < 95) begin
         send(OP_STOP, tag, $urandom, now_t);
      end else if (pick < 98) begin
         send(OP_RESTART, tag, $urandom, now_t);
      end else begin
         req_operation <= 3'($urandom_range(6, 7));
         req_valid <= 1;
         req_task_tag <= tag;
         req_time_value <= $urandom;
         req_now <= now_t;
         do @(posedge clock); while (req_stall);
         sb.note(op_type'(req_operation), tag, req_time_value, now_t);
      end
   endtask

   initial begin
      logic [4:0] limits[6];
      sb = new();
      sb.clear_all();
      limits = '{5'd16, 5'd1, 5'd3, 5'd31, 5'd0, 5'd8};
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      send(OP_POST, 16'h0000, 32'h0, 32'h0);
      send(OP_POST, 16'hffff, 32'hffff_ffff, 32'hffff_ffff);
      send(OP_POST_AT, 16'h1234, 32'h0, 32'h0);
      send(OP_POST_AT, 16'h4321, 32'hffff_ffff, 32'h0);
      send(OP_POST_AT, 16'h5555, 32'h10, 32'h0);
      send(OP_POST_AT, 16'haaaa, 32'h10, 32'h0);
      send(OP_POST_AFTER, 16'h0f0f, 32'h0, 32'h100);
      send(OP_POST_AFTER, 16'hf0f0, 32'h1, 32'hffff_ffff);
      send(OP_POST_AFTER, 16'h00ff, 32'hffff_ffff, 32'h2);
      for (int i = 0; i < 6; i++) send(OP_POLL, 16'h0, 32'h0, 32'h10);
      send(OP_POLL, 16'h0, 32'h0, 32'hffff_ffff);
      send(OP_POLL, 16'h0, 32'h0, 32'hffff_ffff);
      send(OP_STOP, 16'h0, 32'h0, 32'h0);
      send(OP_STOP, 16'h0, 32'h0, 32'h0);
      send(OP_POST, 16'hbeef, 32'h0, 32'h0);
      send(OP_POLL, 16'h0, 32'h0, 32'hffff_ffff);
      send(OP_RESTART, 16'h0, 32'h0, 32'h0);
      send(op_type'(3'd6), 16'h0, 32'h0, 32'h0);
      send(op_type'(3'd7), 16'hffff, 32'hffff_ffff, 32'hffff_ffff);
      send(OP_POLL, 16'h0, 32'h0, 32'h0);

      for (int ph = 0; ph < 6; ph++) begin
         write_limit(limits[ph]);
         if (ph == 5) idle_on = 0;
         if (ph == 1) long_hold_go = 1;
         for (int n = 0; n < 290; n++) begin
            if (ph == 2 && n == 140) drain();
            random_item();
         end
      end

      drain();
      $display("ran %0d requests over six pending limits: %0d tasks handed out, %0d posts refused",
               sb.items, sb.handed_out, sb.refused);
      if (sb.errors == 0 && sb.outcome_q.size() == 0) begin
         $display("delayed_task_queue: match");
      end else begin
         $display("%0d mismatches", sb.errors);
         $display("delayed_task_queue: mismatch");
      end
      $finish;
   end
endmodule
